// ===== hdl/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and codes of the circle raster painter.
// ----------------------------------------------------------------------------
package crp_pkg;

	localparam int CENTER_W = 20;
	localparam int RADIUS_W = 19;
	localparam int BYTE_W   = 8;
	localparam int DIMCFG_W = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] SHAPE_DISC = 8'h43;
	localparam logic [BYTE_W-1:0] SHAPE_RING = 8'h63;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_DRAW  = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH      = 2'd0,
		CFG_HEIGHT     = 2'd1,
		CFG_BACKGROUND = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [1:0]                 mode;
		logic signed [CENTER_W-1:0] center_x;
		logic signed [CENTER_W-1:0] center_y;
		logic [RADIUS_W-1:0]        radius;
		logic [BYTE_W-1:0]          shape_code;
		logic [BYTE_W-1:0]          paint_color;
		logic [BYTE_W-1:0]          read_col;
		logic [BYTE_W-1:0]          read_row;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] pixel_value;
		logic              error_seen;
	} result_t;

endpackage

// ===== hdl/crp_ram.sv =====
// ----------------------------------------------------------------------------
// crp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module crp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/circle_raster_painter.sv =====
// ----------------------------------------------------------------------------
// circle_raster_painter
// Character canvas in one RAM with clear, circle draw and cell read commands.
// ----------------------------------------------------------------------------
// A command item is taken at a clock edge with start high and busy low.
// Clear sweeps the whole RAM, 4**max(1, ceil(log2(MAX_DIM))) cells (65536 at the
// default size), one cell per cycle, busy all the while.
// Draw spends a setup state on the squared radii, then streams every
// in-use cell through a three-stage distance pipeline, one cell per cycle,
// and drains it, busy all the while. A draw that is bad or blocked by the
// sticky error starts nothing and leaves busy low.
// A read's result is on result for one cycle, marked by result_strobe, in
// the cycle after the item, and reads may follow each other in every cycle
// while busy is low. The receiver cannot stall; results are never held.
// Configuration writes are taken in every cycle (cfg_ready is always high)
// and are meant to happen while no command is running.
// Reset clears the error flag, the controller and the registers to their
// defaults; the canvas RAM is not cleared and holds nothing defined until
// a clear command has run.
// ----------------------------------------------------------------------------
module circle_raster_painter #(
	parameter int MAX_DIM   = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  crp_pkg::cmd_t                       cmd,
	output crp_pkg::result_t                    result,
	output logic                                result_strobe,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [crp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crp_pkg::DIMCFG_W-1:0]        cfg_data
);

	localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = 2 * CNT_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int PX_W   = CNT_W + FRAC_BITS;
	localparam int AD_W   = ((PX_W > crp_pkg::CENTER_W - 1) ? PX_W : crp_pkg::CENTER_W - 1) + 1;
	localparam int DIFF_W = AD_W + 1;
	localparam int SQ_W   = 2 * AD_W;
	localparam int D2_W   = SQ_W + 1;
	localparam int R_W    = crp_pkg::RADIUS_W;
	localparam int R2_W   = 2 * R_W;
	localparam int EW     = (crp_pkg::DIMCFG_W > CNT_W + 1) ? crp_pkg::DIMCFG_W : CNT_W + 1;
	localparam int RW     = (crp_pkg::BYTE_W > CNT_W) ? crp_pkg::BYTE_W : CNT_W;

	localparam logic [EW-1:0]    MAXD = EW'(MAX_DIM);
	localparam logic [R_W-1:0]   ONE  = R_W'(1 << FRAC_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = '1;

	crp_pkg::state_t state_q, state_d;

	logic [crp_pkg::DIMCFG_W-1:0] width_q, height_q;
	logic [crp_pkg::BYTE_W-1:0]   bg_q;
	logic                         error_q;
	logic [CNT_W-1:0]             row_q, col_q;

	logic signed [crp_pkg::CENTER_W-1:0] cx_q, cy_q;
	logic [R_W-1:0]                      r_q;
	logic [crp_pkg::BYTE_W-1:0]          color_q;
	logic                                disc_q, thin_q;
	logic [R2_W-1:0]                     r2_q, inner_q;

	logic              v_s1, v_s2;
	logic [AD_W-1:0]   adx_s1, ady_s1;
	logic [ADDR_W-1:0] addr_s1, addr_s2, addr_s3;
	logic [SQ_W-1:0]   dx2_s2, dy2_s2;
	logic              paint_s3;

	logic rd_pend_q, rd_inrange_q;

	logic accept, is_draw, is_read, bad_draw, draw_go;
	logic [CNT_W-1:0] last_col, last_row;
	logic [EW-1:0]    w_ext, h_ext;
	logic             rd_inrange;

	logic                     ram_we, ram_re;
	logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
	logic [crp_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

	logic [PX_W-1:0]          px, py;
	logic signed [DIFF_W-1:0] dx, dy;
	logic [R_W-1:0]           rm1;
	logic [R2_W-1:0]          r2_c, inner_c;
	logic [D2_W-1:0]          d2;
	logic                     scan_row_end, scan_end;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != crp_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign is_draw   = accept && (cmd.mode == crp_pkg::MODE_DRAW);
	assign is_read   = accept && (cmd.mode == crp_pkg::MODE_READ);
	assign bad_draw  = (cmd.radius == '0) ||
		((cmd.shape_code != crp_pkg::SHAPE_DISC) && (cmd.shape_code != crp_pkg::SHAPE_RING));
	assign draw_go   = is_draw && !error_q && !bad_draw;

	// saturate the size registers to 1..MAX_DIM, kept as last index
	assign w_ext = EW'(width_q);
	assign h_ext = EW'(height_q);

	always_comb begin
		if (w_ext == '0) begin
			last_col = '0;
		end else if (w_ext > MAXD) begin
			last_col = CNT_W'(MAXD - EW'(1));
		end else begin
			last_col = CNT_W'(w_ext - EW'(1));
		end
		if (h_ext == '0) begin
			last_row = '0;
		end else if (h_ext > MAXD) begin
			last_row = CNT_W'(MAXD - EW'(1));
		end else begin
			last_row = CNT_W'(h_ext - EW'(1));
		end
	end

	assign rd_inrange = (RW'(cmd.read_col) <= RW'(last_col)) &&
		(RW'(cmd.read_row) <= RW'(last_row));

	assign scan_row_end = (col_q == last_col);
	assign scan_end     = scan_row_end && (row_q == last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= crp_pkg::DIMCFG_W'(256);
			height_q <= crp_pkg::DIMCFG_W'(256);
			bg_q     <= crp_pkg::BYTE_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				crp_pkg::CFG_WIDTH:      width_q  <= cfg_data;
				crp_pkg::CFG_HEIGHT:     height_q <= cfg_data;
				crp_pkg::CFG_BACKGROUND: bg_q     <= cfg_data[crp_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			crp_pkg::ST_IDLE: begin
				if (accept && (cmd.mode == crp_pkg::MODE_CLEAR)) begin
					state_d = crp_pkg::ST_CLEAR;
				end else if (draw_go) begin
					state_d = crp_pkg::ST_SETUP;
				end
			end
			crp_pkg::ST_CLEAR: begin
				if ((col_q == CNT_LAST) && (row_q == CNT_LAST)) begin
					state_d = crp_pkg::ST_IDLE;
				end
			end
			crp_pkg::ST_SETUP: state_d = crp_pkg::ST_SCAN;
			crp_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = crp_pkg::ST_DRAIN;
				end
			end
			crp_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = crp_pkg::ST_IDLE;
				end
			end
			default: state_d = crp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (state_q == crp_pkg::ST_CLEAR) begin
			col_q <= col_q + CNT_W'(1);
			if (col_q == CNT_LAST) begin
				row_q <= row_q + CNT_W'(1);
			end
		end else if (state_q == crp_pkg::ST_SCAN) begin
			if (scan_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (scan_row_end) begin
				col_q <= '0;
				row_q <= row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q <= 1'b0;
		end else if (is_draw && !error_q && bad_draw) begin
			error_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_go) begin
			cx_q    <= cmd.center_x;
			cy_q    <= cmd.center_y;
			r_q     <= cmd.radius;
			color_q <= cmd.paint_color;
			disc_q  <= (cmd.shape_code == crp_pkg::SHAPE_DISC);
		end
	end

	assign rm1     = r_q - ONE;
	assign r2_c    = r_q * r_q;
	assign inner_c = rm1 * rm1;

	always_ff @(posedge clk) begin
		if (state_q == crp_pkg::ST_SETUP) begin
			r2_q    <= r2_c;
			inner_q <= inner_c;
			thin_q  <= (r_q < ONE);
		end
	end

	// distance pipeline
	assign px = PX_W'(col_q) << FRAC_BITS;
	assign py = PX_W'(row_q) << FRAC_BITS;
	assign dx = DIFF_W'(px) - DIFF_W'(cx_q);
	assign dy = DIFF_W'(py) - DIFF_W'(cy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			paint_s3 <= 1'b0;
		end else begin
			v_s1     <= (state_q == crp_pkg::ST_SCAN);
			v_s2     <= v_s1;
			paint_s3 <= v_s2 && (d2 <= D2_W'(r2_q)) &&
				(disc_q || thin_q || (d2 > D2_W'(inner_q)));
		end
	end

	always_ff @(posedge clk) begin
		adx_s1  <= AD_W'(dx[DIFF_W-1] ? -dx : dx);
		ady_s1  <= AD_W'(dy[DIFF_W-1] ? -dy : dy);
		addr_s1 <= {row_q, col_q};
		dx2_s2  <= adx_s1 * adx_s1;
		dy2_s2  <= ady_s1 * ady_s1;
		addr_s2 <= addr_s1;
		addr_s3 <= addr_s2;
	end

	assign d2 = D2_W'(dx2_s2) + D2_W'(dy2_s2);

	always_comb begin
		if (state_q == crp_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = {row_q, col_q};
			ram_wdata = bg_q;
		end else begin
			ram_we    = paint_s3;
			ram_waddr = addr_s3;
			ram_wdata = color_q;
		end
	end

	assign ram_re    = is_read;
	assign ram_raddr = {CNT_W'(cmd.read_row), CNT_W'(cmd.read_col)};

	crp_ram #(
		.WIDTH(crp_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_canvas (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q    <= 1'b0;
			rd_inrange_q <= 1'b0;
		end else begin
			rd_pend_q    <= is_read;
			rd_inrange_q <= rd_inrange;
		end
	end

	assign result_strobe      = rd_pend_q;
	assign result.pixel_value = rd_inrange_q ? ram_rdata : '0;
	assign result.error_seen  = error_q;

	a_strobe_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(start && !busy && (cmd.mode == crp_pkg::MODE_READ)))
		else $error("result strobe without a read item");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crp_pkg::ST_IDLE) |-> !ram_we)
		else $error("canvas written while idle");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		error_q |=> error_q)
		else $error("error flag dropped");

	a_pipe_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ((state_q == crp_pkg::ST_SCAN) || (state_q == crp_pkg::ST_DRAIN)))
		else $error("pixel in flight outside a draw");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circle raster painter. Command items come from
// a backlog queue that the stimulus block fills phase by phase. A clocked
// driver sends them in bursts with random gaps. Every accepted item is
// replayed on a behavioral copy of the canvas, the error flag and the
// registers. Each read result is compared field by field against the oldest
// predicted answer.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_DIM     = 256;
	localparam int FRAC        = 8;
	localparam int DRAIN_GAP   = 8;
	localparam int CYCLE_LIMIT = 4000000;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam longint unsigned ONE_UNIT = 64'd1 << FRAC;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	crp_pkg::cmd_t     cmd = '0;
	crp_pkg::result_t  result;
	logic              result_strobe;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [crp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [crp_pkg::DIMCFG_W-1:0]  cfg_data = '0;

	circle_raster_painter #(
		.MAX_DIM  (MAX_DIM),
		.FRAC_BITS(FRAC)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result       (result),
		.result_strobe(result_strobe),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// shadow state of the painter
	logic [7:0]                   canvas_copy [0:MAX_DIM*MAX_DIM-1];
	logic                         error_copy = 1'b0;
	logic [crp_pkg::DIMCFG_W-1:0] width_reg  = 9'd256;
	logic [crp_pkg::DIMCFG_W-1:0] height_reg = 9'd256;
	logic [7:0]                   bg_reg     = 8'd32;

	crp_pkg::cmd_t    cmd_backlog [$];
	crp_pkg::result_t read_answers [$];
	int unsigned items_left = 0;
	int unsigned mismatch_count = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic note_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic int unsigned used_dim(logic [crp_pkg::DIMCFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return 32'(v);
	endfunction

	task automatic paint_circle(crp_pkg::cmd_t c);
		longint          cx, cy, px, py;
		longint unsigned r, r2, inner, dx, dy, d2;
		bit              thin;
		int unsigned     w, h;
		cx = longint'(c.center_x);
		cy = longint'(c.center_y);
		r = 64'(c.radius);
		r2 = r * r;
		thin = r < ONE_UNIT;
		inner = thin ? 64'd0 : (r - ONE_UNIT) * (r - ONE_UNIT);
		w = used_dim(width_reg);
		h = used_dim(height_reg);
		for (int unsigned row = 0; row < h; row++) begin
			py = longint'(row) << FRAC;
			dy = (py >= cy) ? py - cy : cy - py;
			for (int unsigned col = 0; col < w; col++) begin
				px = longint'(col) << FRAC;
				dx = (px >= cx) ? px - cx : cx - px;
				d2 = dx * dx + dy * dy;
				if (d2 <= r2 && (c.shape_code == crp_pkg::SHAPE_DISC || thin || d2 > inner))
					canvas_copy[row * MAX_DIM + col] = c.paint_color;
			end
		end
	endtask

	task automatic predict_command(crp_pkg::cmd_t c);
		crp_pkg::result_t ans;
		case (c.mode)
			crp_pkg::MODE_CLEAR: begin
				for (int i = 0; i < MAX_DIM * MAX_DIM; i++)
					canvas_copy[i] = bg_reg;
			end
			crp_pkg::MODE_DRAW: begin
				if (!error_copy) begin
					if (c.radius == 0 || (c.shape_code != crp_pkg::SHAPE_DISC &&
							c.shape_code != crp_pkg::SHAPE_RING))
						error_copy = 1'b1;
					else
						paint_circle(c);
				end
			end
			crp_pkg::MODE_READ: begin
				ans.pixel_value = 8'd0;
				if (c.read_col < used_dim(width_reg) && c.read_row < used_dim(height_reg))
					ans.pixel_value = canvas_copy[{c.read_row, c.read_col}];
				ans.error_seen = error_copy;
				read_answers.push_back(ans);
			end
			default: begin
			end
		endcase
	endtask

	// command driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && busy) begin
			// item held until the painter takes it
		end else begin
			if (start) begin
				predict_command(cmd);
				items_left--;
			end
			if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				cmd <= cmd_backlog.pop_front();
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
						: $urandom_range(1, 6);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end else begin
					burst_left--;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		crp_pkg::result_t want;
		if (arst_n && result_strobe === 1'b1) begin
			if (read_answers.size() == 0) begin
				note_mismatch("unexpected result", 32'(result), 0);
			end else begin
				want = read_answers.pop_front();
				if (result.pixel_value !== want.pixel_value)
					note_mismatch("pixel_value", 32'(result.pixel_value),
						32'(want.pixel_value));
				if (result.error_seen !== want.error_seen)
					note_mismatch("error_seen", 32'(result.error_seen),
						32'(want.error_seen));
			end
		end
	end

	function automatic crp_pkg::cmd_t random_fields();
		crp_pkg::cmd_t c;
		logic [31:0]   a, b, d;
		a = $urandom();
		b = $urandom();
		d = $urandom();
		c.mode        = a[1:0];
		c.read_col    = a[9:2];
		c.center_x    = a[31:12];
		c.center_y    = b[19:0];
		c.shape_code  = b[27:20];
		c.radius      = d[18:0];
		c.paint_color = d[26:19];
		c.read_row    = {b[31:28], d[30:27]};
		return c;
	endfunction

	function automatic crp_pkg::cmd_t clear_cmd();
		crp_pkg::cmd_t c;
		c = random_fields();
		c.mode = crp_pkg::MODE_CLEAR;
		return c;
	endfunction

	function automatic crp_pkg::cmd_t read_cmd(logic [7:0] col, logic [7:0] row);
		crp_pkg::cmd_t c;
		c = random_fields();
		c.mode = crp_pkg::MODE_READ;
		c.read_col = col;
		c.read_row = row;
		return c;
	endfunction

	function automatic crp_pkg::cmd_t draw_cmd(logic signed [crp_pkg::CENTER_W-1:0] cx,
			logic signed [crp_pkg::CENTER_W-1:0] cy, logic [crp_pkg::RADIUS_W-1:0] r,
			logic [7:0] shape, logic [7:0] color);
		crp_pkg::cmd_t c;
		c = random_fields();
		c.mode = crp_pkg::MODE_DRAW;
		c.center_x = cx;
		c.center_y = cy;
		c.radius = r;
		c.shape_code = shape;
		c.paint_color = color;
		return c;
	endfunction

	function automatic crp_pkg::cmd_t random_draw(int unsigned w, int unsigned h, bit wild);
		crp_pkg::cmd_t c;
		int            cx, cy;
		int unsigned   span, pick;
		logic [31:0]   rv;
		c = random_fields();
		c.mode = crp_pkg::MODE_DRAW;
		span = ((w > h) ? w : h) << FRAC;
		pick = $urandom_range(0, 7);
		if (pick != 7) begin
			cx = int'($urandom_range(0, (w + 1) << FRAC)) - 128;
			cy = int'($urandom_range(0, (h + 1) << FRAC)) - 128;
			c.center_x = cx[crp_pkg::CENTER_W-1:0];
			c.center_y = cy[crp_pkg::CENTER_W-1:0];
			rv = (pick == 0) ? $urandom_range(1, 255) : $urandom_range(1, span + 256);
			c.radius = rv[crp_pkg::RADIUS_W-1:0];
		end else if (c.radius == 0) begin
			c.radius = 19'd1;
		end
		if (!wild || $urandom_range(0, 1) == 0)
			c.shape_code = ($urandom_range(0, 1) == 0) ? crp_pkg::SHAPE_DISC
				: crp_pkg::SHAPE_RING;
		if (wild && $urandom_range(0, 5) == 0)
			c.radius = '0;
		return c;
	endfunction

	task automatic post(crp_pkg::cmd_t c);
		cmd_backlog.push_back(c);
		items_left++;
	endtask

	task automatic queue_random(int n, bit wild);
		int unsigned   w, h, k;
		logic [31:0]   rv;
		crp_pkg::cmd_t c;
		w = used_dim(width_reg);
		h = used_dim(height_reg);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 19);
			if (k < 8) begin
				c = random_draw(w, h, wild);
			end else if (k < 18) begin
				c = random_fields();
				c.mode = crp_pkg::MODE_READ;
				if ($urandom_range(0, 4) != 0) begin
					rv = $urandom_range(0, w - 1);
					c.read_col = rv[7:0];
					rv = $urandom_range(0, h - 1);
					c.read_row = rv[7:0];
				end
			end else begin
				c = random_fields();
				c.mode = MODE_UNUSED;
			end
			post(c);
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (items_left != 0 || cmd_backlog.size() != 0 || start);
		repeat (DRAIN_GAP) @(posedge clk);
		while (busy || read_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(crp_pkg::cfg_reg_t idx, logic [crp_pkg::DIMCFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			crp_pkg::CFG_WIDTH:      width_reg = value;
			crp_pkg::CFG_HEIGHT:     height_reg = value;
			crp_pkg::CFG_BACKGROUND: bg_reg = value[7:0];
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_canvas(logic [crp_pkg::DIMCFG_W-1:0] w,
			logic [crp_pkg::DIMCFG_W-1:0] h, logic [crp_pkg::DIMCFG_W-1:0] bg);
		write_reg(crp_pkg::CFG_WIDTH, w);
		write_reg(crp_pkg::CFG_HEIGHT, h);
		write_reg(crp_pkg::CFG_BACKGROUND, bg);
	endtask

	initial begin : stimulus
		logic [31:0]   rv;
		crp_pkg::cmd_t c;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// full canvas at reset defaults
		post(clear_cmd());
		post(read_cmd(8'd0, 8'd0));
		post(read_cmd(8'd255, 8'd255));
		post(draw_cmd(20'h08000, 20'h08000, 19'h00A00, crp_pkg::SHAPE_DISC, 8'h41));
		post(read_cmd(8'd128, 8'd128));
		post(read_cmd(8'd138, 8'd128));
		post(read_cmd(8'd139, 8'd128));
		// ring edge: distance equal to radius minus one stays unpainted
		post(draw_cmd(20'h08000, 20'h08000, 19'h01400, crp_pkg::SHAPE_RING, 8'hFF));
		post(read_cmd(8'd148, 8'd128));
		post(read_cmd(8'd147, 8'd128));
		post(read_cmd(8'd128, 8'd128));
		wait_idle();

		set_canvas(9'd5, 9'd4, 9'h1AB);
		post(clear_cmd());
		// ring thinner than one unit
		post(draw_cmd(20'h00280, 20'h00180, 19'h000C0, crp_pkg::SHAPE_RING, 8'h00));
		post(draw_cmd(20'h80000, 20'h7FFFF, 19'h7FFFF, crp_pkg::SHAPE_DISC, 8'hFF));
		post(draw_cmd(20'h00000, 20'h00000, 19'h00001, crp_pkg::SHAPE_DISC, 8'h5A));
		post(read_cmd(8'd0, 8'd0));
		post(read_cmd(8'd2, 8'd1));
		post(read_cmd(8'd4, 8'd3));
		post(read_cmd(8'd5, 8'd0));
		post(read_cmd(8'd0, 8'd4));
		post(read_cmd(8'd255, 8'd255));
		c = draw_cmd(20'h00000, 20'h00000, 19'h00001, 8'h00, 8'h00);
		c.mode = MODE_UNUSED;
		post(c);
		post(read_cmd(8'd3, 8'd2));
		wait_idle();

		// random phases over several canvas shapes
		set_canvas(9'd256, 9'd1, 9'd0);
		post(clear_cmd());
		queue_random(12, 1'b0);
		wait_idle();

		set_canvas(9'd1, 9'd256, 9'd255);
		post(clear_cmd());
		queue_random(12, 1'b0);
		wait_idle();

		// out-of-range sizes saturate
		set_canvas(9'd0, 9'd511, 9'h100);
		queue_random(10, 1'b0);
		wait_idle();

		rv = $urandom();
		set_canvas(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)), rv[8:0]);
		post(clear_cmd());
		queue_random(12, 1'b0);
		wait_idle();

		set_canvas(9'($urandom_range(1, 24)), 9'($urandom_range(1, 24)), 9'd32);
		queue_random(12, 1'b0);
		wait_idle();

		// sticky error: zero radius, then unknown shape and a valid draw are blocked
		set_canvas(9'($urandom_range(2, 12)), 9'($urandom_range(2, 12)), 9'h02E);
		post(clear_cmd());
		post(draw_cmd(20'h00100, 20'h00100, 19'h00180, crp_pkg::SHAPE_DISC, 8'h2A));
		post(read_cmd(8'd1, 8'd1));
		post(draw_cmd(20'h00100, 20'h00100, 19'h00000, crp_pkg::SHAPE_DISC, 8'h55));
		post(read_cmd(8'd1, 8'd1));
		post(draw_cmd(20'h00100, 20'h00100, 19'h00300, 8'h9C, 8'h55));
		post(draw_cmd(20'h00000, 20'h00000, 19'h00400, crp_pkg::SHAPE_RING, 8'h77));
		post(read_cmd(8'd0, 8'd0));
		queue_random(10, 1'b1);
		wait_idle();

		repeat (DRAIN_GAP * 4) @(posedge clk);
		if (read_answers.size() != 0)
			note_mismatch("results never came", 0, 32'(read_answers.size()));
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
